// File: hw/rtl/irfc_pkg.sv
package irfc_pkg;

    localparam int MAX_DIM   = 128;
    localparam int DIM_BITS  = $clog2(MAX_DIM);
    localparam int SIZE_BITS = DIM_BITS + 1;
    localparam int ADDR_BITS = 2 * DIM_BITS;
    localparam int PIX_BITS  = 16;
    localparam int OP_BITS   = 3;
    localparam int WIN_BITS  = 8;
    localparam int CFG_BITS  = 8;
    localparam int IDX_BITS  = 2;

    // orientation bits
    localparam int OR_SWAP = 0;
    localparam int OR_MROW = 1;
    localparam int OR_MCOL = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_ROTATE = 3'd2,
        OP_CROP   = 3'd3,
        OP_HFLIP  = 3'd4,
        OP_VFLIP  = 3'd5
    } op_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_INIT_ROWS = 2'd0,
        REG_INIT_COLS = 2'd1
    } reg_idx_t;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [DIM_BITS-1:0] row;
        logic [DIM_BITS-1:0] col;
        logic [PIX_BITS-1:0] pix;
        logic                turn_right;
        logic [1:0]          turns;
        logic [WIN_BITS-1:0] wl;
        logic [WIN_BITS-1:0] wr;
        logic [WIN_BITS-1:0] wt;
        logic [WIN_BITS-1:0] wb;
    } cmd_t;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [ADDR_BITS-1:0] addr;
        logic [PIX_BITS-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic done;
        logic rd_ok;
        logic status;
    } res_t;

    function automatic logic [SIZE_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
        logic [SIZE_BITS-1:0] r;
        if (v == '0)
            r = SIZE_BITS'(1);
        else if (v > CFG_BITS'(MAX_DIM))
            r = SIZE_BITS'(MAX_DIM);
        else
            r = SIZE_BITS'(v);
        return r;
    endfunction

endpackage

// File: hw/rtl/irfc_frame_ram.sv
module irfc_frame_ram #(
    parameter int AW = 14,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/irfc_geom.sv
module irfc_geom (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  irfc_pkg::cmd_t                cmd,
    input  logic                          cfg_we,
    input  logic [irfc_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [irfc_pkg::CFG_BITS-1:0] cfg_data,
    output irfc_pkg::mem_req_t            mem_req,
    output irfc_pkg::res_t                res,
    output logic [irfc_pkg::SIZE_BITS-1:0] rows,
    output logic [irfc_pkg::SIZE_BITS-1:0] cols
);
    import irfc_pkg::*;

    logic [CFG_BITS-1:0]  init_rows_reg, init_rows_next;
    logic [CFG_BITS-1:0]  init_cols_reg, init_cols_next;
    logic [2:0]           orient_reg, orient_next;
    logic [DIM_BITS-1:0]  org_row_reg, org_row_next;
    logic [DIM_BITS-1:0]  org_col_reg, org_col_next;
    logic [SIZE_BITS-1:0] rows_reg, rows_next;
    logic [SIZE_BITS-1:0] cols_reg, cols_next;
    res_t                 res_reg, res_next;

    logic                 in_range;
    logic [DIM_BITS-1:0]  r_m, c_m, p_r, p_c;
    logic                 bad_win;
    logic [DIM_BITS-1:0]  roff, coff;
    logic [1:0]           k;
    logic [2:0]           o_t;
    logic [SIZE_BITS-1:0] r_t, c_t, sw_t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_rows_reg <= CFG_BITS'(MAX_DIM);
            init_cols_reg <= CFG_BITS'(MAX_DIM);
            orient_reg    <= '0;
            org_row_reg   <= '0;
            org_col_reg   <= '0;
            rows_reg      <= SIZE_BITS'(MAX_DIM);
            cols_reg      <= SIZE_BITS'(MAX_DIM);
            res_reg       <= '0;
        end
        else
        begin
            init_rows_reg <= init_rows_next;
            init_cols_reg <= init_cols_next;
            orient_reg    <= orient_next;
            org_row_reg   <= org_row_next;
            org_col_reg   <= org_col_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            res_reg       <= res_next;
        end
    end

    // logical -> store coordinate mapping
    always_comb
    begin
        in_range = ({1'b0, cmd.row} < rows_reg) && ({1'b0, cmd.col} < cols_reg);
        r_m = orient_reg[OR_MROW] ? DIM_BITS'(rows_reg - SIZE_BITS'(1) - {1'b0, cmd.row})
                                  : cmd.row;
        c_m = orient_reg[OR_MCOL] ? DIM_BITS'(cols_reg - SIZE_BITS'(1) - {1'b0, cmd.col})
                                  : cmd.col;
        p_r = orient_reg[OR_SWAP] ? c_m : r_m;
        p_c = orient_reg[OR_SWAP] ? r_m : c_m;
        mem_req.addr  = {DIM_BITS'(org_row_reg + p_r), DIM_BITS'(org_col_reg + p_c)};
        mem_req.wdata = cmd.pix;
        mem_req.we    = accept && (op_t'(cmd.op) == OP_WRITE) && in_range;
        mem_req.re    = accept && (op_t'(cmd.op) == OP_READ) && in_range;
    end

    // crop window check and origin offsets
    always_comb
    begin
        bad_win = (cmd.wt == '0) || (cmd.wt > cmd.wb) || ({1'b0, cmd.wb} > {1'b0, rows_reg})
               || (cmd.wl == '0) || (cmd.wl > cmd.wr) || ({1'b0, cmd.wr} > {1'b0, cols_reg});
        roff = orient_reg[OR_MROW] ? DIM_BITS'(rows_reg - SIZE_BITS'(cmd.wb))
                                   : DIM_BITS'(cmd.wt - WIN_BITS'(1));
        coff = orient_reg[OR_MCOL] ? DIM_BITS'(cols_reg - SIZE_BITS'(cmd.wr))
                                   : DIM_BITS'(cmd.wl - WIN_BITS'(1));
    end

    // rotation: k counterclockwise quarter turns, at most three
    always_comb
    begin
        k    = cmd.turn_right ? 2'(2'd0 - cmd.turns) : cmd.turns;
        o_t  = orient_reg;
        r_t  = rows_reg;
        c_t  = cols_reg;
        sw_t = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < k)
            begin
                o_t  = {o_t[OR_MROW], ~o_t[OR_MCOL], ~o_t[OR_SWAP]};
                sw_t = r_t;
                r_t  = c_t;
                c_t  = sw_t;
            end
        end
    end

    always_comb
    begin
        init_rows_next = init_rows_reg;
        init_cols_next = init_cols_reg;
        orient_next    = orient_reg;
        org_row_next   = org_row_reg;
        org_col_next   = org_col_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        res_next       = '0;

        if (cfg_we && (cfg_index == REG_INIT_ROWS || cfg_index == REG_INIT_COLS))
        begin
            if (cfg_index == REG_INIT_ROWS)
                init_rows_next = cfg_data;
            else
                init_cols_next = cfg_data;
            orient_next  = '0;
            org_row_next = '0;
            org_col_next = '0;
            rows_next    = clamp_dim(init_rows_next);
            cols_next    = clamp_dim(init_cols_next);
        end
        else if (accept)
        begin
            res_next.done = 1'b1;
            case (op_t'(cmd.op))
                OP_WRITE:
                begin
                    res_next.status = !in_range;
                end
                OP_READ:
                begin
                    res_next.status = !in_range;
                    res_next.rd_ok  = in_range;
                end
                OP_ROTATE:
                begin
                    orient_next = o_t;
                    rows_next   = r_t;
                    cols_next   = c_t;
                end
                OP_CROP:
                begin
                    if (bad_win)
                        res_next.status = 1'b1;
                    else
                    begin
                        if (orient_reg[OR_SWAP])
                        begin
                            org_row_next = DIM_BITS'(org_row_reg + coff);
                            org_col_next = DIM_BITS'(org_col_reg + roff);
                        end
                        else
                        begin
                            org_row_next = DIM_BITS'(org_row_reg + roff);
                            org_col_next = DIM_BITS'(org_col_reg + coff);
                        end
                        rows_next = SIZE_BITS'(cmd.wb - cmd.wt + WIN_BITS'(1));
                        cols_next = SIZE_BITS'(cmd.wr - cmd.wl + WIN_BITS'(1));
                    end
                end
                OP_HFLIP:
                begin
                    orient_next[OR_MCOL] = ~orient_reg[OR_MCOL];
                end
                OP_VFLIP:
                begin
                    orient_next[OR_MROW] = ~orient_reg[OR_MROW];
                end
                default:
                begin
                    res_next.status = 1'b1;
                end
            endcase
        end
    end

    assign res  = res_reg;
    assign rows = rows_reg;
    assign cols = cols_reg;

`ifndef SYNTH
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_we |=> res_reg.done)
        else $error("result strobe missing after accepted command");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !res_reg.done)
        else $error("result strobe without command");
    a_rd_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.rd_ok |-> res_reg.done && !res_reg.status)
        else $error("read data flagged on failed command");
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg != '0 && cols_reg != '0
        && rows_reg <= SIZE_BITS'(MAX_DIM) && cols_reg <= SIZE_BITS'(MAX_DIM))
        else $error("image size out of range");
    a_window_fits: assert property (@(posedge clk) disable iff (!rst_n)
        orient_reg[OR_SWAP]
            ? ({1'b0, org_row_reg} + cols_reg <= SIZE_BITS'(MAX_DIM)
               && {1'b0, org_col_reg} + rows_reg <= SIZE_BITS'(MAX_DIM))
            : ({1'b0, org_row_reg} + rows_reg <= SIZE_BITS'(MAX_DIM)
               && {1'b0, org_col_reg} + cols_reg <= SIZE_BITS'(MAX_DIM)))
        else $error("window extends past frame store");
`endif

endmodule

// File: hw/rtl/image_rotate_flip_crop_core.sv
// Each command taken with cfg_we low gives one result word on done in the next cycle.
// Throughput: one command per cycle; busy stays low, the result path never stalls.
// The rate is set by the one-port frame store: at most one mapped access per command.
// Reset (rst_n, async, active low): identity orientation, origin zero, 128 x 128 size.
// Frame store contents are not cleared; a pixel must be written before it is read.
// The receiver cannot stall: done marks each result for exactly one cycle.
module image_rotate_flip_crop_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [irfc_pkg::OP_BITS-1:0]   op,
    input  logic [irfc_pkg::DIM_BITS-1:0]  row,
    input  logic [irfc_pkg::DIM_BITS-1:0]  col,
    input  logic signed [irfc_pkg::PIX_BITS-1:0] pixel_in,
    input  logic                           turn_right,
    input  logic [15:0]                    turns,
    input  logic [irfc_pkg::WIN_BITS-1:0]  win_left,
    input  logic [irfc_pkg::WIN_BITS-1:0]  win_right,
    input  logic [irfc_pkg::WIN_BITS-1:0]  win_top,
    input  logic [irfc_pkg::WIN_BITS-1:0]  win_bottom,
    // result channel
    output logic                           done,
    output logic signed [irfc_pkg::PIX_BITS-1:0] pixel_out,
    output logic [irfc_pkg::SIZE_BITS-1:0] cur_rows,
    output logic [irfc_pkg::SIZE_BITS-1:0] cur_cols,
    output logic                           status,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [irfc_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [irfc_pkg::CFG_BITS-1:0]  cfg_data
);
    import irfc_pkg::*;

    logic                 accept;
    cmd_t                 cmd;
    mem_req_t             mem_req;
    res_t                 res;
    logic [PIX_BITS-1:0]  rd_data;

    // No command ever waits: geometry updates and the store access both
    // complete at the accept edge.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Only the low two bits of the turn count matter (quarter turns mod 4).
    always_comb
    begin
        cmd.op         = op;
        cmd.row        = row;
        cmd.col        = col;
        cmd.pix        = pixel_in;
        cmd.turn_right = turn_right;
        cmd.turns      = turns[1:0];
        cmd.wl         = win_left;
        cmd.wr         = win_right;
        cmd.wt         = win_top;
        cmd.wb         = win_bottom;
    end

    // Geometry tracker: orientation code, window origin and size. Maps each
    // pixel access to a store address and forms the status word.
    irfc_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .res       (res),
        .rows      (cur_rows),
        .cols      (cur_cols)
    );

    // Frame store: one port, registered read. A write followed by a read of
    // the same pixel on the next cycle sees the new value.
    irfc_frame_ram #(
        .AW (ADDR_BITS),
        .DW (PIX_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rd_data)
    );

    // Read data lands in the same cycle as the strobe; all other words show zero.
    assign done      = res.done;
    assign status    = res.status;
    assign pixel_out = res.rd_ok ? rd_data : '0;

endmodule

// File: dv/tb_image_rotate_flip_crop_core.sv
typedef struct {
    logic [irfc_pkg::OP_BITS-1:0]  op;
    logic [irfc_pkg::DIM_BITS-1:0] row;
    logic [irfc_pkg::DIM_BITS-1:0] col;
    logic [irfc_pkg::PIX_BITS-1:0] pix;
    logic                          turn_right;
    logic [15:0]                   turns;
    logic [irfc_pkg::WIN_BITS-1:0] wl;
    logic [irfc_pkg::WIN_BITS-1:0] wr;
    logic [irfc_pkg::WIN_BITS-1:0] wt;
    logic [irfc_pkg::WIN_BITS-1:0] wb;
} edit_word_t;

typedef struct {
    logic [irfc_pkg::PIX_BITS-1:0]  pixel;
    logic [irfc_pkg::SIZE_BITS-1:0] rows;
    logic [irfc_pkg::SIZE_BITS-1:0] cols;
    logic                           status;
} reply_t;

// Tracks orientation, window and frame contents; queues the reply due for each word.
class frame_edit_sb;
    logic [irfc_pkg::PIX_BITS-1:0] pixels [irfc_pkg::MAX_DIM * irfc_pkg::MAX_DIM];
    bit                            written [irfc_pkg::MAX_DIM * irfc_pkg::MAX_DIM];
    int unsigned                   written_list [$];
    logic [2:0]                    orient;
    int                            org_row;
    int                            org_col;
    int                            rows_now;
    int                            cols_now;
    logic [irfc_pkg::CFG_BITS-1:0] init_rows;
    logic [irfc_pkg::CFG_BITS-1:0] init_cols;
    reply_t                        replies_due [$];
    int                            errs;

    function new();
        init_rows = 8'd128;
        init_cols = 8'd128;
        errs = 0;
        reload();
    endfunction

    function int eff_dim(logic [irfc_pkg::CFG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > irfc_pkg::MAX_DIM)
            return irfc_pkg::MAX_DIM;
        return int'(v);
    endfunction

    function void reload();
        orient = 3'b000;
        org_row = 0;
        org_col = 0;
        rows_now = eff_dim(init_rows);
        cols_now = eff_dim(init_cols);
    endfunction

    function void load_reg(logic [irfc_pkg::IDX_BITS-1:0] idx,
                           logic [irfc_pkg::CFG_BITS-1:0] v);
        if (idx == irfc_pkg::REG_INIT_ROWS) begin
            init_rows = v;
            reload();
        end else if (idx == irfc_pkg::REG_INIT_COLS) begin
            init_cols = v;
            reload();
        end
    endfunction

    function int unsigned store_addr(int r, int c);
        int a;
        int b;
        int pr;
        int pc;
        a = orient[irfc_pkg::OR_MROW] ? rows_now - 1 - r : r;
        b = orient[irfc_pkg::OR_MCOL] ? cols_now - 1 - c : c;
        pr = orient[irfc_pkg::OR_SWAP] ? b : a;
        pc = orient[irfc_pkg::OR_SWAP] ? a : b;
        return (org_row + pr) * irfc_pkg::MAX_DIM + org_col + pc;
    endfunction

    // inverse of store_addr; 0 when the entry lies outside the current window
    function bit locate(int unsigned addr, output int r, output int c);
        int sr;
        int sc;
        int a;
        int b;
        sr = int'(addr / irfc_pkg::MAX_DIM) - org_row;
        sc = int'(addr % irfc_pkg::MAX_DIM) - org_col;
        a = orient[irfc_pkg::OR_SWAP] ? sc : sr;
        b = orient[irfc_pkg::OR_SWAP] ? sr : sc;
        r = 0;
        c = 0;
        if (a < 0 || a >= rows_now || b < 0 || b >= cols_now)
            return 0;
        r = orient[irfc_pkg::OR_MROW] ? rows_now - 1 - a : a;
        c = orient[irfc_pkg::OR_MCOL] ? cols_now - 1 - b : b;
        return 1;
    endfunction

    function bit reads_unwritten(edit_word_t w);
        if (w.op != irfc_pkg::OP_READ || w.row >= rows_now || w.col >= cols_now)
            return 0;
        return !written[store_addr(w.row, w.col)];
    endfunction

    function void quarter_ccw();
        logic [2:0] o;
        int t;
        o = orient;
        orient[irfc_pkg::OR_SWAP] = ~o[irfc_pkg::OR_SWAP];
        orient[irfc_pkg::OR_MROW] = ~o[irfc_pkg::OR_MCOL];
        orient[irfc_pkg::OR_MCOL] = o[irfc_pkg::OR_MROW];
        t = rows_now;
        rows_now = cols_now;
        cols_now = t;
    endfunction

    function bit apply_crop(int l, int r, int t, int b);
        int roff;
        int coff;
        if (t < 1 || t > b || b > rows_now || l < 1 || l > r || r > cols_now)
            return 0;
        roff = orient[irfc_pkg::OR_MROW] ? rows_now - b : t - 1;
        coff = orient[irfc_pkg::OR_MCOL] ? cols_now - r : l - 1;
        if (orient[irfc_pkg::OR_SWAP]) begin
            org_row += coff;
            org_col += roff;
        end else begin
            org_row += roff;
            org_col += coff;
        end
        rows_now = b - t + 1;
        cols_now = r - l + 1;
        return 1;
    endfunction

    function void note_cmd(edit_word_t w);
        reply_t      want;
        int unsigned a;
        int          k;
        want.pixel = '0;
        want.status = 1'b0;
        case (w.op)
            irfc_pkg::OP_WRITE, irfc_pkg::OP_READ: begin
                if (w.row >= rows_now || w.col >= cols_now) begin
                    want.status = 1'b1;
                end else begin
                    a = store_addr(w.row, w.col);
                    if (w.op == irfc_pkg::OP_WRITE) begin
                        pixels[a] = w.pix;
                        if (!written[a])
                            written_list.push_back(a);
                        written[a] = 1'b1;
                    end else begin
                        want.pixel = pixels[a];
                    end
                end
            end
            irfc_pkg::OP_ROTATE: begin
                k = int'(w.turns[1:0]);
                if (w.turn_right)
                    k = (4 - k) % 4;
                repeat (k) quarter_ccw();
            end
            irfc_pkg::OP_CROP: begin
                if (!apply_crop(w.wl, w.wr, w.wt, w.wb))
                    want.status = 1'b1;
            end
            irfc_pkg::OP_HFLIP: orient[irfc_pkg::OR_MCOL] = ~orient[irfc_pkg::OR_MCOL];
            irfc_pkg::OP_VFLIP: orient[irfc_pkg::OR_MROW] = ~orient[irfc_pkg::OR_MROW];
            default: want.status = 1'b1;
        endcase
        want.rows = rows_now[irfc_pkg::SIZE_BITS-1:0];
        want.cols = cols_now[irfc_pkg::SIZE_BITS-1:0];
        replies_due.push_back(want);
    endfunction

    task report_mismatch(string what);
        errs++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_reply(reply_t got);
        reply_t want;
        if (replies_due.size() == 0) begin
            report_mismatch("reply word with nothing outstanding");
            return;
        end
        want = replies_due.pop_front();
        if (got.pixel !== want.pixel)
            report_mismatch($sformatf("pixel_out %h, want %h", got.pixel, want.pixel));
        if (got.rows !== want.rows)
            report_mismatch($sformatf("cur_rows %0d, want %0d", got.rows, want.rows));
        if (got.cols !== want.cols)
            report_mismatch($sformatf("cur_cols %0d, want %0d", got.cols, want.cols));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %b, want %b", got.status, want.status));
    endtask

    task finish_check();
        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d reply words never came", replies_due.size()));
    endtask
endclass

module tb_image_rotate_flip_crop_core;
    timeunit 1ns;
    timeprecision 1ps;

    import irfc_pkg::*;

    // Generous bound for ~1200 words with idle gaps and drains.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;   // block answers in the cycle after taking a word
    localparam int IDLE_PCT      = 17;
    localparam int QUIET_FROM    = 400; // words in [QUIET_FROM, QUIET_TO) get no random idle gaps
    localparam int QUIET_TO      = 650;
    localparam int PHASES        = 12;

    // unused op codes and register slots; the block must flag or ignore them
    localparam logic [OP_BITS-1:0]  OP_UNUSED_LO = 3'd6;
    localparam logic [OP_BITS-1:0]  OP_UNUSED_HI = 3'd7;
    localparam logic [IDX_BITS-1:0] REG_SPARE_2  = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_SPARE_3  = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [OP_BITS-1:0]          op;
    logic [DIM_BITS-1:0]         row;
    logic [DIM_BITS-1:0]         col;
    logic signed [PIX_BITS-1:0]  pixel_in;
    logic                        turn_right;
    logic [15:0]                 turns;
    logic [WIN_BITS-1:0]         win_left;
    logic [WIN_BITS-1:0]         win_right;
    logic [WIN_BITS-1:0]         win_top;
    logic [WIN_BITS-1:0]         win_bottom;
    logic                        done;
    logic signed [PIX_BITS-1:0]  pixel_out;
    logic [SIZE_BITS-1:0]        cur_rows;
    logic [SIZE_BITS-1:0]        cur_cols;
    logic                        status;
    logic                        cfg_we;
    logic [IDX_BITS-1:0]         cfg_index;
    logic [CFG_BITS-1:0]         cfg_data;

    frame_edit_sb model = new();
    int unsigned  cycle_count = 0;
    int           issued = 0;

    image_rotate_flip_crop_core i_dut (.*);

    // 4 ns clock, 2 ns high and 2 ns low
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Reply words: done marks each one for a single cycle; sampled at the closing edge.
    always @(posedge clk) begin
        reply_t got;
        if (rst_n === 1'b1 && done === 1'b1) begin
            got.pixel  = pixel_out;
            got.rows   = cur_rows;
            got.cols   = cur_cols;
            got.status = status;
            model.check_reply(got);
        end
    end

    // Every field random; callers overwrite what the op needs, so unused
    // fields still toggle every bit.
    function automatic edit_word_t rand_word();
        edit_word_t w;
        w.op         = OP_BITS'($urandom);
        w.row        = DIM_BITS'($urandom);
        w.col        = DIM_BITS'($urandom);
        w.pix        = PIX_BITS'($urandom);
        w.turn_right = 1'($urandom);
        w.turns      = 16'($urandom);
        w.wl         = WIN_BITS'($urandom);
        w.wr         = WIN_BITS'($urandom);
        w.wt         = WIN_BITS'($urandom);
        w.wb         = WIN_BITS'($urandom);
        return w;
    endfunction

    // Drive one command word at the falling edge, hold it until taken, then
    // hand it to the model. start is only ever set once per falling edge.
    task automatic issue(edit_word_t w);
        @(negedge clk);
        // a read must never touch a frame entry that was never written
        if (model.reads_unwritten(w))
            w.op = OP_WRITE;
        start      <= 1'b1;
        op         <= w.op;
        row        <= w.row;
        col        <= w.col;
        pixel_in   <= w.pix;
        turn_right <= w.turn_right;
        turns      <= w.turns;
        win_left   <= w.wl;
        win_right  <= w.wr;
        win_top    <= w.wt;
        win_bottom <= w.wb;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        model.note_cmd(w);
        issued++;
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // random idle gaps before each word, except inside the quiet stretch
    task automatic send(edit_word_t w);
        while ((issued < QUIET_FROM || issued >= QUIET_TO) && $urandom_range(0, 99) < IDLE_PCT)
            idle_cycle();
        issue(w);
    endtask

    task automatic cmd_access(logic [OP_BITS-1:0] o, int r, int c, logic [15:0] pix);
        edit_word_t w;
        w = rand_word();
        w.op  = o;
        w.row = DIM_BITS'(r);
        w.col = DIM_BITS'(c);
        w.pix = pix;
        send(w);
    endtask

    // read whatever logical pixel now maps onto frame entry addr, else a random one
    task automatic cmd_read_at(int unsigned addr);
        edit_word_t w;
        int         r;
        int         c;
        w = rand_word();
        w.op = OP_READ;
        if (model.locate(addr, r, c)) begin
            w.row = DIM_BITS'(r);
            w.col = DIM_BITS'(c);
        end
        send(w);
    endtask

    task automatic cmd_rotate(logic right, logic [15:0] n);
        edit_word_t w;
        w = rand_word();
        w.op = OP_ROTATE;
        w.turn_right = right;
        w.turns = n;
        send(w);
    endtask

    task automatic cmd_crop(int l, int r, int t, int b);
        edit_word_t w;
        w = rand_word();
        w.op = OP_CROP;
        w.wl = WIN_BITS'(l);
        w.wr = WIN_BITS'(r);
        w.wt = WIN_BITS'(t);
        w.wb = WIN_BITS'(b);
        send(w);
    endtask

    task automatic cmd_plain(logic [OP_BITS-1:0] o);
        edit_word_t w;
        w = rand_word();
        w.op = o;
        send(w);
    endtask

    // Mostly well-formed traffic: in-range accesses, reads of pixels known to
    // be written, legal crop windows; otherwise random accesses, windows and bad ops.
    task automatic make_random(output edit_word_t w);
        int  pick;
        int  r;
        int  c;
        int  k;
        bit  found;
        int  rows;
        int  cols;
        w = rand_word();
        rows = model.rows_now;
        cols = model.cols_now;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            w.op = OP_WRITE;
            if ($urandom_range(0, 9) != 0) begin
                w.row = DIM_BITS'($urandom_range(0, rows - 1));
                w.col = DIM_BITS'($urandom_range(0, cols - 1));
            end
        end else if (pick < 62) begin
            w.op = OP_READ;
            if ($urandom_range(0, 9) != 0) begin
                found = 1'b0;
                repeat (8) begin
                    if (!found && model.written_list.size() != 0) begin
                        k = $urandom_range(0, model.written_list.size() - 1);
                        found = model.locate(model.written_list[k], r, c);
                    end
                end
                if (found) begin
                    w.row = DIM_BITS'(r);
                    w.col = DIM_BITS'(c);
                end else begin
                    // nothing readable in the window yet: fill a pixel instead
                    w.op  = OP_WRITE;
                    w.row = DIM_BITS'($urandom_range(0, rows - 1));
                    w.col = DIM_BITS'($urandom_range(0, cols - 1));
                end
            end
        end else if (pick < 72) begin
            w.op = OP_ROTATE;
        end else if (pick < 80) begin
            w.op = OP_CROP;
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 1) != 0) begin
                    w.wt = WIN_BITS'($urandom_range(1, rows));
                    w.wb = WIN_BITS'($urandom_range(w.wt, rows));
                    w.wl = WIN_BITS'($urandom_range(1, cols));
                    w.wr = WIN_BITS'($urandom_range(w.wl, cols));
                end else begin
                    // trim a little so the image does not collapse too fast
                    w.wt = WIN_BITS'($urandom_range(1, rows < 2 ? rows : 2));
                    w.wb = WIN_BITS'($urandom_range(rows - 1 > w.wt ? rows - 1 : w.wt, rows));
                    w.wl = WIN_BITS'($urandom_range(1, cols < 2 ? cols : 2));
                    w.wr = WIN_BITS'($urandom_range(cols - 1 > w.wl ? cols - 1 : w.wl, cols));
                end
            end
        end else if (pick < 88) begin
            w.op = OP_HFLIP;
        end else if (pick < 96) begin
            w.op = OP_VFLIP;
        end else begin
            w.op = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
        end
    endtask

    task automatic run_random(int n);
        edit_word_t w;
        repeat (n) begin
            make_random(w);
            send(w);
        end
    endtask

    // Register write; only ever called with the block idle.
    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        model.load_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stop issuing and wait until every outstanding reply word has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (model.replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [CFG_BITS-1:0] nr;
        logic [CFG_BITS-1:0] nc;
        start      = 1'b0;
        op         = '0;
        row        = '0;
        col        = '0;
        pixel_in   = '0;
        turn_right = 1'b0;
        turns      = '0;
        win_left   = '0;
        win_right  = '0;
        win_top    = '0;
        win_bottom = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset geometry is 128 x 128, identity orientation.
        // corner pixels with extreme values
        cmd_access(OP_WRITE, 0, 0, 16'h7FFF);
        cmd_access(OP_WRITE, 127, 127, 16'h8000);
        cmd_access(OP_WRITE, 0, 127, 16'hFFFF);
        cmd_access(OP_WRITE, 127, 0, 16'h0001);
        cmd_access(OP_READ, 0, 0, 16'h0000);
        cmd_access(OP_READ, 127, 127, 16'h0000);
        // each rotation form, including turn counts that wrap mod 4
        cmd_rotate(1'b1, 16'd1);
        cmd_read_at(0);
        cmd_read_at(127);
        cmd_rotate(1'b0, 16'hFFFF);
        cmd_rotate(1'b1, 16'd0);
        cmd_rotate(1'b0, 16'd2);
        // flips
        cmd_plain(OP_HFLIP);
        cmd_read_at(127 * MAX_DIM);
        cmd_plain(OP_VFLIP);
        cmd_read_at(127 * MAX_DIM + 127);
        // unknown ops
        cmd_plain(OP_UNUSED_LO);
        cmd_plain(OP_UNUSED_HI);
        // every way a crop window can be bad, then a legal one
        cmd_crop(1, 128, 0, 128);
        cmd_crop(1, 128, 5, 4);
        cmd_crop(1, 128, 1, 129);
        cmd_crop(0, 128, 1, 128);
        cmd_crop(9, 8, 1, 128);
        cmd_crop(1, 255, 1, 128);
        cmd_crop(2, 127, 3, 126);
        // now 124 x 126: both accesses fall outside
        cmd_access(OP_WRITE, 127, 0, 16'h5A5A);
        cmd_access(OP_READ, 0, 127, 16'h0000);
        drain();

        // Random phases, each under its own register setting. Two phases write
        // only a spare index, which must leave the geometry as it was.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin nr = 8'd0;   nc = 8'd255; end
                1:       begin nr = 8'd255; nc = 8'd0;   end
                2:       begin nr = 8'd1;   nc = 8'd1;   end
                3:       begin nr = 8'd128; nc = 8'd128; end
                4:       begin nr = 8'd129; nc = 8'd2;   end
                5:       begin nr = 8'd2;   nc = 8'd64;  end
                default: begin
                    nr = $urandom_range(0, 3) == 0 ? CFG_BITS'($urandom)
                                                    : CFG_BITS'($urandom_range(1, 128));
                    nc = $urandom_range(0, 3) == 0 ? CFG_BITS'($urandom)
                                                    : CFG_BITS'($urandom_range(1, 128));
                end
            endcase
            if (p == 6)
                write_reg(REG_SPARE_2, nr);
            else if (p == 9)
                write_reg(REG_SPARE_3, nc);
            else begin
                write_reg(REG_INIT_ROWS, nr);
                write_reg(REG_INIT_COLS, nc);
            end
            run_random(p == 2 ? 40 : 100);
            drain();
        end

        model.finish_check();
        if (model.errs == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
